// ----- sv/sphere_vertex_renormalize_unit_assert.svh -----
// Assertion macros for the sphere vertex renormalize unit.
`ifndef SPHERE_VERTEX_RENORMALIZE_UNIT_ASSERT_SVH
`define SPHERE_VERTEX_RENORMALIZE_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, idle during reset.
`define SVR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on clk, idle during reset.
`define SVR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- sv/svr_pkg.sv -----
// Types and constants shared by the sphere vertex renormalize unit.
package svr_pkg;

  localparam int CW  = 32;          // coordinate width
  localparam int DW  = CW + 1;      // signed difference width
  localparam int MW  = CW + 1;      // magnitude width
  localparam int SQW = 2 * MW;      // sum of squares width
  localparam int LW  = MW;          // length (root) width
  localparam int RMW = LW + 2;      // root remainder width
  localparam int RW  = 31;          // radius width
  localparam int NW  = MW + RW + 1; // numerator width
  localparam int QW  = RW;          // quotient width
  localparam int AW  = 4;           // APB address width

  localparam logic [RW-1:0] RADIUS_RST = RW'(6553600);

  typedef enum logic [1:0] {
    REG_RADIUS   = 2'd0,
    REG_CENTER_X = 2'd1,
    REG_CENTER_Y = 2'd2,
    REG_CENTER_Z = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    VERD_NONE        = 2'd0,
    VERD_REGULAR     = 2'd1,
    VERD_IRREGULAR   = 2'd2,
    VERD_ALL_INVALID = 2'd3
  } verdict_t;

  typedef struct packed {
    logic signed [CW-1:0] vert_x;
    logic signed [CW-1:0] vert_y;
    logic signed [CW-1:0] vert_z;
    logic                 vert_invalid;
    logic                 last_vertex;
  } in_item_t;

  typedef struct packed {
    logic signed [CW-1:0] out_x;
    logic signed [CW-1:0] out_y;
    logic signed [CW-1:0] out_z;
    logic                 forced_to_axis;
    logic [1:0]           verdict;
    logic [LW-1:0]        min_length;
    logic [LW-1:0]        max_length;
  } out_item_t;

endpackage

// ----- sv/sphere_vertex_renormalize_unit.sv -----
// Top level: center subtract, pipelined square root and divide, length statistics.
//
//  port group | direction | handshake        | payload
//  in_        | input     | in_valid/ready   | svr_pkg::in_item_t
//  out_       | output    | out_valid/ready  | svr_pkg::out_item_t
//  APB        | input     | psel/penable     | paddr, pwdata, prdata
//
// One item per cycle unless the output stalls; 4 front stages, 33 root stages one bit
// each, 1 multiply stage, 31 divide stages one quotient bit each, 1 output stage.
// rst_n is synchronous; it empties the pipeline, clears statistics and the center
// registers, and sets the radius to RADIUS_RST. A stalled output freezes the whole
// pipeline; in_ready is high whenever the output register is empty or being taken.
`include "sphere_vertex_renormalize_unit_assert.svh"

module sphere_vertex_renormalize_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  svr_pkg::in_item_t           in_item,
  output logic                        out_valid,
  input  logic                        out_ready,
  output svr_pkg::out_item_t          out_item,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [svr_pkg::AW-1:0]      paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  localparam int NST  = 4 + svr_pkg::LW + 1 + svr_pkg::QW + 1;
  localparam int LWI  = svr_pkg::LW;
  localparam int QWI  = svr_pkg::QW;

  // configuration registers
  logic [svr_pkg::RW-1:0]        radius_r;
  logic signed [svr_pkg::CW-1:0] cen_r [0:2];
  svr_pkg::reg_idx_t             widx;

  assign pready = 1'b1;
  assign widx   = svr_pkg::reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= svr_pkg::RADIUS_RST;
      cen_r[0] <= '0;
      cen_r[1] <= '0;
      cen_r[2] <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (widx)
        svr_pkg::REG_RADIUS:   radius_r <= pwdata[svr_pkg::RW-1:0];
        svr_pkg::REG_CENTER_X: cen_r[0] <= pwdata[svr_pkg::CW-1:0];
        svr_pkg::REG_CENTER_Y: cen_r[1] <= pwdata[svr_pkg::CW-1:0];
        svr_pkg::REG_CENTER_Z: cen_r[2] <= pwdata[svr_pkg::CW-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (widx)
      svr_pkg::REG_RADIUS:   prdata = {1'b0, radius_r};
      svr_pkg::REG_CENTER_X: prdata = cen_r[0];
      svr_pkg::REG_CENTER_Y: prdata = cen_r[1];
      svr_pkg::REG_CENTER_Z: prdata = cen_r[2];
    endcase
  end

  // global advance and valid shift line
  logic           adv;
  logic [NST-1:0] vld_r;

  assign adv       = !vld_r[NST-1] || out_ready;
  assign in_ready  = adv;
  assign out_valid = vld_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NST-2:0], in_valid};
    end
  end

  // front stages: difference, magnitude, squares, sum
  logic signed [svr_pkg::DW-1:0] a_d_r   [0:2];
  logic                          a_inv_r, a_last_r;
  logic [svr_pkg::MW-1:0]        b_mag_r [0:2];
  logic [2:0]                    b_neg_r;
  logic                          b_inv_r, b_last_r;
  logic [svr_pkg::SQW-1:0]       c_sq_r  [0:2];
  logic [svr_pkg::MW-1:0]        c_mag_r [0:2];
  logic [2:0]                    c_neg_r;
  logic                          c_inv_r, c_last_r;
  logic signed [svr_pkg::CW-1:0] vin     [0:2];

  assign vin[0] = in_item.vert_x;
  assign vin[1] = in_item.vert_y;
  assign vin[2] = in_item.vert_z;

  // root stages, index 0 is the sum of squares
  logic [svr_pkg::SQW-1:0] sq_rad_r  [0:LWI];
  logic [svr_pkg::RMW-1:0] sq_rem_r  [0:LWI];
  logic [svr_pkg::LW-1:0]  sq_root_r [0:LWI];
  logic [svr_pkg::MW-1:0]  sq_mag_r  [0:LWI][0:2];
  logic [2:0]              sq_neg_r  [0:LWI];
  logic                    sq_inv_r  [0:LWI];
  logic                    sq_last_r [0:LWI];
  logic [svr_pkg::RMW-1:0] sq_rem_nxt  [1:LWI];
  logic [svr_pkg::LW-1:0]  sq_root_nxt [1:LWI];

  always_comb begin
    logic [svr_pkg::RMW-1:0] rem2;
    logic [svr_pkg::RMW-1:0] trial;
    for (int k = 1; k <= LWI; k++) begin
      rem2  = {sq_rem_r[k-1][svr_pkg::RMW-3:0],
               sq_rad_r[k-1][svr_pkg::SQW-1:svr_pkg::SQW-2]};
      trial = {sq_root_r[k-1], 2'b01};
      if (rem2 >= trial) begin
        sq_rem_nxt[k]  = rem2 - trial;
        sq_root_nxt[k] = {sq_root_r[k-1][svr_pkg::LW-2:0], 1'b1};
      end else begin
        sq_rem_nxt[k]  = rem2;
        sq_root_nxt[k] = {sq_root_r[k-1][svr_pkg::LW-2:0], 1'b0};
      end
    end
  end

  // divide stages, index 0 holds the rounded numerator
  logic [svr_pkg::LW:0]    dv_rem_r    [0:QWI][0:2];
  logic [svr_pkg::QW-1:0]  dv_lq_r     [0:QWI][0:2];
  logic [svr_pkg::LW-1:0]  dv_len_r    [0:QWI];
  logic [2:0]              dv_neg_r    [0:QWI];
  logic                    dv_forced_r [0:QWI];
  logic                    dv_last_r   [0:QWI];
  logic [svr_pkg::LW:0]    dv_rem_nxt  [1:QWI][0:2];
  logic [svr_pkg::QW-1:0]  dv_lq_nxt   [1:QWI][0:2];
  logic [svr_pkg::NW-1:0]  e_num       [0:2];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      e_num[c] = svr_pkg::NW'(sq_mag_r[LWI][c]) * svr_pkg::NW'(radius_r)
               + svr_pkg::NW'(sq_root_r[LWI] >> 1);
    end
  end

  always_comb begin
    logic [svr_pkg::LW:0] rem2;
    for (int j = 1; j <= QWI; j++) begin
      for (int c = 0; c < 3; c++) begin
        rem2 = {dv_rem_r[j-1][c][svr_pkg::LW-1:0], dv_lq_r[j-1][c][svr_pkg::QW-1]};
        if (rem2 >= {1'b0, dv_len_r[j-1]}) begin
          dv_rem_nxt[j][c] = rem2 - {1'b0, dv_len_r[j-1]};
          dv_lq_nxt[j][c]  = {dv_lq_r[j-1][c][svr_pkg::QW-2:0], 1'b1};
        end else begin
          dv_rem_nxt[j][c] = rem2;
          dv_lq_nxt[j][c]  = {dv_lq_r[j-1][c][svr_pkg::QW-2:0], 1'b0};
        end
      end
    end
  end

  // datapath registers, all moving together on advance
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < 3; c++) begin
        a_d_r[c]   <= svr_pkg::DW'(vin[c]) - svr_pkg::DW'(cen_r[c]);
        b_neg_r[c] <= a_d_r[c][svr_pkg::DW-1];
        b_mag_r[c] <= a_d_r[c][svr_pkg::DW-1] ? svr_pkg::MW'(-a_d_r[c])
                                              : svr_pkg::MW'(a_d_r[c]);
        c_sq_r[c]  <= b_mag_r[c] * b_mag_r[c];
        c_mag_r[c] <= b_mag_r[c];
        sq_mag_r[0][c] <= c_mag_r[c];
      end
      a_inv_r  <= in_item.vert_invalid;
      a_last_r <= in_item.last_vertex;
      b_inv_r  <= a_inv_r;
      b_last_r <= a_last_r;
      c_neg_r  <= b_neg_r;
      c_inv_r  <= b_inv_r;
      c_last_r <= b_last_r;

      sq_rad_r[0]  <= c_sq_r[0] + c_sq_r[1] + c_sq_r[2];
      sq_rem_r[0]  <= '0;
      sq_root_r[0] <= '0;
      sq_neg_r[0]  <= c_neg_r;
      sq_inv_r[0]  <= c_inv_r;
      sq_last_r[0] <= c_last_r;
      for (int k = 1; k <= LWI; k++) begin
        sq_rad_r[k]  <= {sq_rad_r[k-1][svr_pkg::SQW-3:0], 2'b00};
        sq_rem_r[k]  <= sq_rem_nxt[k];
        sq_root_r[k] <= sq_root_nxt[k];
        sq_mag_r[k]  <= sq_mag_r[k-1];
        sq_neg_r[k]  <= sq_neg_r[k-1];
        sq_inv_r[k]  <= sq_inv_r[k-1];
        sq_last_r[k] <= sq_last_r[k-1];
      end

      for (int c = 0; c < 3; c++) begin
        dv_rem_r[0][c] <= e_num[c][svr_pkg::NW-1:svr_pkg::QW];
        dv_lq_r[0][c]  <= e_num[c][svr_pkg::QW-1:0];
      end
      dv_len_r[0]    <= sq_root_r[LWI];
      dv_neg_r[0]    <= sq_neg_r[LWI];
      dv_forced_r[0] <= sq_inv_r[LWI] || (sq_root_r[LWI] == '0);
      dv_last_r[0]   <= sq_last_r[LWI];
      for (int j = 1; j <= QWI; j++) begin
        dv_rem_r[j]    <= dv_rem_nxt[j];
        dv_lq_r[j]     <= dv_lq_nxt[j];
        dv_len_r[j]    <= dv_len_r[j-1];
        dv_neg_r[j]    <= dv_neg_r[j-1];
        dv_forced_r[j] <= dv_forced_r[j-1];
        dv_last_r[j]   <= dv_last_r[j-1];
      end
    end
  end

  // tail: signs, forced axis, length statistics and verdict
  logic                 seen_r, seen_nxt;
  logic [svr_pkg::LW-1:0] least_r, least_nxt, great_r, great_nxt;
  logic                 tail_fire;
  svr_pkg::out_item_t   out_nxt, out_r;
  logic signed [svr_pkg::CW-1:0] scaled [0:2];

  assign tail_fire = adv && vld_r[NST-2];

  always_comb begin
    logic [svr_pkg::CW-1:0] q;
    for (int c = 0; c < 3; c++) begin
      q = {{(svr_pkg::CW - svr_pkg::QW){1'b0}}, dv_lq_r[QWI][c]};
      scaled[c] = dv_neg_r[QWI][c] ? -q : q;
    end
  end

  always_comb begin
    seen_nxt  = seen_r;
    least_nxt = least_r;
    great_nxt = great_r;
    if (!dv_forced_r[QWI]) begin
      if (!seen_r) begin
        seen_nxt  = 1'b1;
        least_nxt = dv_len_r[QWI];
        great_nxt = dv_len_r[QWI];
      end else begin
        if (dv_len_r[QWI] < least_r) least_nxt = dv_len_r[QWI];
        if (dv_len_r[QWI] > great_r) great_nxt = dv_len_r[QWI];
      end
    end

    if (dv_forced_r[QWI]) begin
      out_nxt.out_x = {{(svr_pkg::CW - svr_pkg::RW){1'b0}}, radius_r};
      out_nxt.out_y = '0;
      out_nxt.out_z = '0;
    end else begin
      out_nxt.out_x = scaled[0];
      out_nxt.out_y = scaled[1];
      out_nxt.out_z = scaled[2];
    end
    out_nxt.forced_to_axis = dv_forced_r[QWI];
    out_nxt.min_length     = least_nxt;
    out_nxt.max_length     = great_nxt;

    // irregular when 20*max > 21*min
    priority if (!dv_last_r[QWI]) begin
      out_nxt.verdict = svr_pkg::VERD_NONE;
    end else if (!seen_nxt) begin
      out_nxt.verdict = svr_pkg::VERD_ALL_INVALID;
    end else if ((svr_pkg::LW + 5)'(great_nxt) * 20 > (svr_pkg::LW + 5)'(least_nxt) * 21) begin
      out_nxt.verdict = svr_pkg::VERD_IRREGULAR;
    end else begin
      out_nxt.verdict = svr_pkg::VERD_REGULAR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r  <= 1'b0;
      least_r <= '0;
      great_r <= '0;
    end else if (tail_fire) begin
      if (dv_last_r[QWI]) begin
        seen_r  <= 1'b0;
        least_r <= '0;
        great_r <= '0;
      end else begin
        seen_r  <= seen_nxt;
        least_r <= least_nxt;
        great_r <= great_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= out_nxt;
    end
  end

  assign out_item = out_r;

  // checks
  `SVR_ASSERT_IMP(a_forced_on_axis, out_valid && out_r.forced_to_axis,
                  out_r.out_y == '0 && out_r.out_z == '0)
  `SVR_ASSERT_IMP(a_all_invalid_empty, out_valid && out_r.verdict == svr_pkg::VERD_ALL_INVALID,
                  out_r.min_length == '0 && out_r.max_length == '0)
  `SVR_ASSERT_IMP(a_min_le_max, out_valid, out_r.min_length <= out_r.max_length)
  `SVR_ASSERT_NXT(a_stats_cleared, tail_fire && dv_last_r[QWI], !seen_r)

endmodule
